FILE: design/upcp_pkg.sv
// Shared constants, key tables and controller/datapath interface types for the
// power command line parser. No dependencies.
package upcp_pkg;

    localparam int LINE_DEPTH_DEF = 32;
    localparam int BYTE_W         = 8;
    localparam int DELAY_W        = 32;

    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    localparam int OFF_LEN    = 7;
    localparam int PAUSE_LEN  = 9;
    localparam int RESUME_LEN = 10;

    // ">PwrOff"
    function automatic logic [BYTE_W-1:0] key_off(input logic [3:0] k);
        logic [BYTE_W-1:0] c;
        case (k)
            4'd0:    c = 8'h3E;
            4'd1:    c = 8'h50;
            4'd2:    c = 8'h77;
            4'd3:    c = 8'h72;
            4'd4:    c = 8'h4F;
            4'd5:    c = 8'h66;
            4'd6:    c = 8'h66;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // ">PwrPause"
    function automatic logic [BYTE_W-1:0] key_pause(input logic [3:0] k);
        logic [BYTE_W-1:0] c;
        case (k)
            4'd0:    c = 8'h3E;
            4'd1:    c = 8'h50;
            4'd2:    c = 8'h77;
            4'd3:    c = 8'h72;
            4'd4:    c = 8'h50;
            4'd5:    c = 8'h61;
            4'd6:    c = 8'h75;
            4'd7:    c = 8'h73;
            4'd8:    c = 8'h65;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // ">PwrResume"
    function automatic logic [BYTE_W-1:0] key_resume(input logic [3:0] k);
        logic [BYTE_W-1:0] c;
        case (k)
            4'd0:    c = 8'h3E;
            4'd1:    c = 8'h50;
            4'd2:    c = 8'h77;
            4'd3:    c = 8'h72;
            4'd4:    c = 8'h52;
            4'd5:    c = 8'h65;
            4'd6:    c = 8'h73;
            4'd7:    c = 8'h75;
            4'd8:    c = 8'h6D;
            4'd9:    c = 8'h65;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    typedef struct packed {
        logic load;         // capture input byte, clear event flags
        logic drop;         // full store: empty it, flag the drop
        logic append;       // write byte at fill count
        logic scan_start;   // reset walk counter and match state
        logic scan_rd;      // issue one store read and advance
        logic finish_line;  // post events, empty the store
        logic out_load;     // move result into the output register
    } cmd_t;

    typedef struct packed {
        logic err;
        logic full;
        logic eol;
        logic scan_last;
        logic out_busy;
    } status_t;

endpackage

FILE: design/upcp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module upcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/upcp_ctrl.sv
// Sequencing state machine of the power command line parser.
// Depends on upcp_pkg (cmd_t, status_t).
module upcp_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  upcp_pkg::status_t status,
    output upcp_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH,
        ST_OUTPUT
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY: begin
                if (status.err) begin
                    state_next = ST_OUTPUT;
                end else if (status.full) begin
                    cmd.drop   = 1'b1;
                    state_next = ST_OUTPUT;
                end else if (status.eol) begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end else begin
                    cmd.append = 1'b1;
                    state_next = ST_OUTPUT;
                end
            end
            ST_SCAN: begin
                cmd.scan_rd = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                cmd.finish_line = 1'b1;
                state_next      = ST_OUTPUT;
            end
            ST_OUTPUT: begin
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: design/upcp_datapath.sv
// Datapath of the power command line parser: line store, fill count, key
// matching, delay accumulation and output register.
// Depends on upcp_pkg and upcp_ram.
module upcp_datapath #(
    parameter int LINE_DEPTH = upcp_pkg::LINE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  upcp_pkg::cmd_t                cmd,
    output upcp_pkg::status_t             status,
    input  logic [upcp_pkg::BYTE_W-1:0]   in_byte,
    input  logic                          in_err,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [upcp_pkg::DELAY_W-1:0]  out_delay,
    output logic                          out_off,
    output logic                          out_pause,
    output logic                          out_resume,
    output logic                          out_dropped
);

    localparam int IDX_W = $clog2(LINE_DEPTH);
    localparam int CNT_W = $clog2(LINE_DEPTH + 1);
    localparam int BW    = upcp_pkg::BYTE_W;
    localparam int DW    = upcp_pkg::DELAY_W;

    logic [BW-1:0]    byte_reg;
    logic             err_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [DW-1:0]    delay_reg, delay_next;
    logic             off_done_reg, off_done_next;
    logic [IDX_W-1:0] scan_idx_reg;
    logic [IDX_W-1:0] eval_pos_reg;
    logic             eval_valid_reg;
    logic             m_off_reg, m_off_next;
    logic             m_pause_reg, m_pause_next;
    logic             m_resume_reg, m_resume_next;
    logic             off_allow_reg;
    logic             skip_reg, skip_next;
    logic             stop_reg, stop_next;
    logic             pause_reg, resume_reg, dropped_reg;
    logic             m_tvalid_reg;
    logic [DW-1:0]    o_delay_reg;
    logic             o_off_reg, o_pause_reg, o_resume_reg, o_dropped_reg;

    logic [BW-1:0]    rd_data;
    logic [BW-1:0]    cur_byte;
    logic             off_active;
    logic [DW-1:0]    d_base;
    logic [DW-1:0]    d_mac;
    logic             is_digit;

    upcp_ram #(
        .WIDTH (BW),
        .DEPTH (LINE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.append),
        .waddr (fill_reg[IDX_W-1:0]),
        .wdata (byte_reg),
        .re    (cmd.scan_rd),
        .raddr (scan_idx_reg),
        .rdata (rd_data)
    );

    assign status.err       = err_reg;
    assign status.full      = (fill_reg == CNT_W'(LINE_DEPTH));
    assign status.eol       = (byte_reg == upcp_pkg::CH_CR) || (byte_reg == upcp_pkg::CH_LF);
    assign status.scan_last = (scan_idx_reg == IDX_W'(LINE_DEPTH - 1));
    assign status.out_busy  = m_tvalid_reg && !m_tready;

    // Entries at or past the fill count read as the cleared value.
    assign cur_byte = (CNT_W'(eval_pos_reg) < fill_reg) ? rd_data : '0;
    assign is_digit = (cur_byte >= upcp_pkg::CH_ZERO) && (cur_byte <= upcp_pkg::CH_NINE);
    assign off_active = eval_valid_reg && off_allow_reg && m_off_reg && !stop_reg
                        && (eval_pos_reg >= IDX_W'(upcp_pkg::OFF_LEN));
    assign d_base = (eval_pos_reg == IDX_W'(upcp_pkg::OFF_LEN)) ? '0 : delay_reg;
    assign d_mac  = {d_base[DW-4:0], 3'b000} + {d_base[DW-2:0], 1'b0}
                    + DW'(cur_byte - upcp_pkg::CH_ZERO);

    always_comb begin
        m_off_next    = m_off_reg;
        m_pause_next  = m_pause_reg;
        m_resume_next = m_resume_reg;
        delay_next    = delay_reg;
        off_done_next = off_done_reg;
        skip_next     = skip_reg;
        stop_next     = stop_reg;
        if (eval_valid_reg) begin
            if (eval_pos_reg < IDX_W'(upcp_pkg::OFF_LEN)) begin
                m_off_next = m_off_reg
                             && (cur_byte == upcp_pkg::key_off(eval_pos_reg[3:0]));
            end
            if (eval_pos_reg < IDX_W'(upcp_pkg::PAUSE_LEN)) begin
                m_pause_next = m_pause_reg
                               && (cur_byte == upcp_pkg::key_pause(eval_pos_reg[3:0]));
            end
            if (eval_pos_reg < IDX_W'(upcp_pkg::RESUME_LEN)) begin
                m_resume_next = m_resume_reg
                                && (cur_byte == upcp_pkg::key_resume(eval_pos_reg[3:0]));
            end
        end
        if (off_active) begin
            delay_next = d_base;
            if (skip_reg && cur_byte == upcp_pkg::CH_SPACE) begin
                skip_next = 1'b1;
            end else begin
                skip_next = 1'b0;
                if (is_digit) begin
                    delay_next = d_mac;
                end else if (cur_byte == upcp_pkg::CH_SPACE) begin
                    off_done_next = 1'b1;
                    stop_next     = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg       <= '0;
            delay_reg      <= '0;
            off_done_reg   <= 1'b0;
            eval_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            pause_reg      <= 1'b0;
            resume_reg     <= 1'b0;
            dropped_reg    <= 1'b0;
        end else begin
            delay_reg      <= delay_next;
            off_done_reg   <= off_done_next;
            eval_valid_reg <= cmd.scan_rd;
            if (cmd.load) begin
                pause_reg   <= 1'b0;
                resume_reg  <= 1'b0;
                dropped_reg <= 1'b0;
            end
            if (cmd.drop) begin
                fill_reg    <= '0;
                dropped_reg <= 1'b1;
            end
            if (cmd.append) begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
            if (cmd.finish_line) begin
                fill_reg   <= '0;
                pause_reg  <= m_pause_reg && !(off_allow_reg && m_off_reg);
                resume_reg <= m_resume_reg && !(off_allow_reg && m_off_reg);
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            byte_reg <= in_byte;
            err_reg  <= in_err;
        end
        if (cmd.scan_start) begin
            scan_idx_reg  <= '0;
            m_off_reg     <= 1'b1;
            m_pause_reg   <= 1'b1;
            m_resume_reg  <= 1'b1;
            off_allow_reg <= !off_done_reg;
            skip_reg      <= 1'b1;
            stop_reg      <= 1'b0;
        end else begin
            m_off_reg    <= m_off_next;
            m_pause_reg  <= m_pause_next;
            m_resume_reg <= m_resume_next;
            skip_reg     <= skip_next;
            stop_reg     <= stop_next;
            if (cmd.scan_rd) begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            end
        end
        if (cmd.scan_rd) begin
            eval_pos_reg <= scan_idx_reg;
        end
        if (cmd.out_load) begin
            o_delay_reg   <= delay_reg;
            o_off_reg     <= off_done_reg;
            o_pause_reg   <= pause_reg;
            o_resume_reg  <= resume_reg;
            o_dropped_reg <= dropped_reg;
        end
    end

    assign m_tvalid    = m_tvalid_reg;
    assign out_delay   = o_delay_reg;
    assign out_off     = o_off_reg;
    assign out_pause   = o_pause_reg;
    assign out_resume  = o_resume_reg;
    assign out_dropped = o_dropped_reg;

endmodule

FILE: design/uart_power_command_line_parser_core.sv
// Top level of the power command line parser: controller plus datapath.
// Depends on upcp_pkg, upcp_ctrl, upcp_datapath (and through it upcp_ram).
//
// Takes received serial bytes one transfer at a time and returns exactly one
// result transfer per byte. Bytes other than CR/LF are appended to a line
// store of LINE_DEPTH bytes; a byte with the error flag set leaves all state
// alone; a byte arriving at a full store discards the line (line_dropped).
// On CR or LF the stored line is walked once from the first entry to the last,
// one entry per clock through the store's read port, matching the command
// keys and accumulating the power-off delay on the way. An ordinary, error or
// dropping byte goes from classification straight to the output state; a line
// end first walks the store memory, then passes a drain and a finish state.
// While the previous result still waits on m_tready, the controller holds in
// its output state and the input stalls for as long. Entries beyond the fill
// count read as zero, so the store needs no clearing pass after reset or
// after a line. A new byte is accepted while the previous result still waits
// in the output register.
module uart_power_command_line_parser_core #(
    parameter int LINE_DEPTH = upcp_pkg::LINE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Received byte channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] rx_error
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [31:0] off_delay_seconds, [32] off_accepted,
                                   // [33] pause_event, [34] resume_event,
                                   // [35] line_dropped, [39:36] zero
);

    upcp_pkg::cmd_t    cmd;
    upcp_pkg::status_t status;

    logic [upcp_pkg::DELAY_W-1:0] out_delay;
    logic out_off, out_pause, out_resume, out_dropped;

    upcp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    upcp_datapath #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .in_byte     (s_tdata),
        .in_err      (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .out_delay   (out_delay),
        .out_off     (out_off),
        .out_pause   (out_pause),
        .out_resume  (out_resume),
        .out_dropped (out_dropped)
    );

    // Pack result fields, lowest first, padded to whole bytes.
    assign m_tdata = {4'b0000, out_dropped, out_resume, out_pause, out_off, out_delay};

endmodule

FILE: tb/sv/uart_power_command_line_parser_core_test.sv
// Self-checking testbench for uart_power_command_line_parser_core: drives received
// bytes on the input stream, predicts every result transfer and checks each field.
// Depends on upcp_pkg and the parser core only.
`timescale 1ns / 1ps

module uart_power_command_line_parser_core_test;

    localparam int DEPTH = upcp_pkg::LINE_DEPTH_DEF;

    // Result layout as carried on m_tdata, lowest field last
    typedef struct packed {
        logic [3:0]  pad;
        logic        dropped;
        logic        resume;
        logic        pause;
        logic        accepted;
        logic [31:0] delay;
    } parse_result_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    uart_power_command_line_parser_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Command words, kept apart from the package tables
    string off_word    = ">PwrOff";
    string pause_word  = ">PwrPause";
    string resume_word = ">PwrResume";

    // Shadow of the parser state
    logic [7:0]  line_buf [DEPTH];
    int unsigned fill_cnt;
    logic [31:0] delay_val;
    logic        off_flag;

    parse_result_t pending_results[$];
    logic [7:0]    draft[$];        // line being built by a generator
    int            errors;
    int            bytes_sent;      // non-error bytes accepted
    bit            quiet;           // no idling on either side
    int            hold_cycles;     // long receiver hold-off request

    // ---------------------------------------------------------------- prediction

    function automatic void clear_line_buf();
        foreach (line_buf[k]) line_buf[k] = 8'h00;
        fill_cnt = 0;
    endfunction

    function automatic bit line_begins(string word);
        int k;
        for (k = 0; k < word.len() && k < DEPTH; k++)
            if (line_buf[k] != word[k]) return 1'b0;
        return 1'b1;
    endfunction

    // Delay walk: skip spaces after the keyword, then digits accumulate until
    // the first space, which accepts the power-off. Other bytes are skipped.
    function automatic void walk_off_delay();
        int          i;
        logic [7:0]  c;
        i = upcp_pkg::OFF_LEN;
        while (i < DEPTH && line_buf[i] == upcp_pkg::CH_SPACE) i++;
        delay_val = '0;
        while (i < DEPTH) begin
            c = line_buf[i];
            if (c >= upcp_pkg::CH_ZERO && c <= upcp_pkg::CH_NINE) begin
                delay_val = delay_val * 32'd10 + 32'(c - upcp_pkg::CH_ZERO);
            end else if (c == upcp_pkg::CH_SPACE) begin
                off_flag = 1'b1;
                break;
            end
            i++;
        end
    endfunction

    function automatic parse_result_t predict_byte(logic [7:0] ch, logic err);
        parse_result_t r;
        r = '0;
        if (!err) begin
            if (fill_cnt >= DEPTH) begin
                clear_line_buf();
                r.dropped = 1'b1;
            end else if (ch == upcp_pkg::CH_CR || ch == upcp_pkg::CH_LF) begin
                if (!off_flag && line_begins(off_word))
                    walk_off_delay();
                else if (line_begins(pause_word))
                    r.pause = 1'b1;
                else if (line_begins(resume_word))
                    r.resume = 1'b1;
                clear_line_buf();
            end else begin
                line_buf[fill_cnt] = ch;
                fill_cnt++;
            end
        end
        r.delay    = delay_val;
        r.accepted = off_flag;
        return r;
    endfunction

    // ------------------------------------------------------------------ checking

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got,
                 want);
        errors++;
    endtask

    always @(posedge aclk) begin : result_check
        parse_result_t got;
        parse_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result transfer", m_tdata[31:0], 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (got.delay !== want.delay)
                    report_mismatch("off_delay_seconds", got.delay, want.delay);
                if (got.accepted !== want.accepted)
                    report_mismatch("off_accepted", 32'(got.accepted),
                                    32'(want.accepted));
                if (got.pause !== want.pause)
                    report_mismatch("pause_event", 32'(got.pause), 32'(want.pause));
                if (got.resume !== want.resume)
                    report_mismatch("resume_event", 32'(got.resume), 32'(want.resume));
                if (got.dropped !== want.dropped)
                    report_mismatch("line_dropped", 32'(got.dropped), 32'(want.dropped));
                if (got.pad !== 4'd0)
                    report_mismatch("tdata padding", 32'(got.pad), 32'd0);
            end
        end
    end

    // Receiver: random stall bursts, or one long hold-off on request
    initial begin
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_cycles != 0) begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(negedge aclk);
                hold_cycles = 0;
                m_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------ stimulus

    // One transfer on the input stream; returns on the falling edge after it
    task automatic send_byte(input logic [7:0] b, input logic err);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tuser  <= 1'($urandom);
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= err;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(predict_byte(b, err));
        if (!err) bytes_sent++;
        @(negedge aclk);
    endtask

    function automatic logic [7:0] text_char();
        logic [7:0] b;
        if ($urandom_range(0, 3) == 0) begin
            b = 8'($urandom_range(0, 255));
            if (b == upcp_pkg::CH_CR || b == upcp_pkg::CH_LF) b = ~b;
        end else begin
            b = 8'($urandom_range(8'h21, 8'h7E));
        end
        return b;
    endfunction

    function automatic void put_word(string w);
        int k;
        for (k = 0; k < w.len(); k++) draft.push_back(w[k]);
    endfunction

    function automatic void trim_draft(int max_len);
        while (draft.size() > max_len) void'(draft.pop_back());
    endfunction

    // Sends the draft, now and then slipping a flagged byte in between
    task automatic send_draft(input bit with_noise);
        int k;
        for (k = 0; k < draft.size(); k++) begin
            if (with_noise && $urandom_range(0, 19) == 0)
                send_byte(8'($urandom_range(0, 255)), 1'b1);
            send_byte(draft[k], 1'b0);
        end
    endtask

    task automatic send_line_end();
        send_byte($urandom_range(0, 1) ? upcp_pkg::CH_CR : upcp_pkg::CH_LF, 1'b0);
    endtask

    task automatic random_line();
        int pick;
        int idx;
        draft.delete();
        pick = $urandom_range(0, 11);
        case (pick) inside
            [0:2]: begin
                put_word(pick == 0 ? pause_word : resume_word);
                if (pick == 2) begin
                    draft.delete();
                    put_word(pause_word);
                end
                repeat ($urandom_range(0, 6)) draft.push_back(text_char());
                trim_draft(DEPTH - 1);
                send_draft(1'b1);
                send_line_end();
            end
            [3:6]: begin
                put_word(off_word);
                repeat ($urandom_range(0, 3)) draft.push_back(upcp_pkg::CH_SPACE);
                repeat ($urandom_range(0, 12))
                    draft.push_back(upcp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
                if ($urandom_range(0, 2) == 0) draft.push_back(text_char());
                if ($urandom_range(0, 7) == 0) begin
                    draft.push_back(upcp_pkg::CH_SPACE);
                    repeat ($urandom_range(0, 4)) draft.push_back(text_char());
                end
                trim_draft(DEPTH - 1);
                send_draft(1'b1);
                send_line_end();
            end
            [7:8]: begin
                // near miss: one byte of a keyword spoilt, or the keyword cut short
                case ($urandom_range(0, 2))
                    0: put_word(off_word);
                    1: put_word(pause_word);
                    default: put_word(resume_word);
                endcase
                if ($urandom_range(0, 1) == 0) begin
                    idx = $urandom_range(0, draft.size() - 1);
                    draft[idx] = text_char();
                end else begin
                    trim_draft($urandom_range(1, draft.size() - 1));
                end
                send_draft(1'b1);
                send_line_end();
            end
            9: begin
                // overlong line: the store fills and the next byte drops it
                repeat ($urandom_range(DEPTH, DEPTH + 8)) draft.push_back(text_char());
                send_draft(1'b1);
                send_line_end();
            end
            default: begin
                repeat ($urandom_range(1, 12)) draft.push_back(8'($urandom_range(0, 255)));
                send_draft(1'b1);
                if ($urandom_range(0, 1) == 0) send_line_end();
            end
        endcase
    endtask

    // ---------------------------------------------------------------- test tasks

    task automatic test_extreme_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(upcp_pkg::CH_CR, 1'b1);     // flagged line end is ignored
        send_byte(upcp_pkg::CH_LF, 1'b0);
        send_byte(upcp_pkg::CH_CR, 1'b0);     // empty line
    endtask

    task automatic test_pause_resume();
        draft.delete();
        put_word(pause_word);
        send_draft(1'b0);
        send_byte(upcp_pkg::CH_CR, 1'b0);
        draft.delete();
        put_word(resume_word);
        send_draft(1'b0);
        send_byte(upcp_pkg::CH_LF, 1'b0);
    endtask

    // Power-off lines without a closing space: delay kept, not accepted
    task automatic test_off_pending();
        draft.delete();
        put_word({off_word, "  42x"});
        send_draft(1'b0);
        send_byte(upcp_pkg::CH_CR, 1'b0);
        draft.delete();
        put_word({off_word, "999999999999"});   // wraps past 32 bits
        send_draft(1'b0);
        send_byte(upcp_pkg::CH_LF, 1'b0);
    endtask

    task automatic test_full_store();
        draft.delete();
        repeat (DEPTH) draft.push_back(8'h41);
        send_draft(1'b0);
        send_byte(upcp_pkg::CH_LF, 1'b0);     // lost to the drop
        send_byte(upcp_pkg::CH_LF, 1'b0);
    endtask

    task automatic test_random_lines();
        quiet = 1'b0;
        while (bytes_sent < 700) random_line();
    endtask

    // Receiver holds off while the sender keeps offering, so input stalls
    task automatic test_back_pressure();
        hold_cycles = 400;
        repeat (3) random_line();
    endtask

    task automatic test_off_accept();
        quiet = 1'b1;
        draft.delete();
        put_word({off_word, " 99999999999 "});
        send_draft(1'b0);
        send_byte(upcp_pkg::CH_CR, 1'b0);
        draft.delete();
        put_word({off_word, " 7 "});            // sticky once accepted
        send_draft(1'b0);
        send_byte(upcp_pkg::CH_LF, 1'b0);
        repeat (8) random_line();
        s_tvalid <= 1'b0;
    endtask

    // -------------------------------------------------------------------- main

    initial begin
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        s_tuser     = 1'b0;
        aresetn     = 1'b0;
        errors      = 0;
        bytes_sent  = 0;
        quiet       = 1'b0;
        hold_cycles = 0;
        clear_line_buf();
        delay_val   = '0;
        off_flag    = 1'b0;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_extreme_bytes();
        test_pause_resume();
        test_off_pending();
        test_full_store();
        test_random_lines();
        test_back_pressure();
        test_off_accept();

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (errors == 0)
            $display("uart_power_command_line_parser_core test passed");
        else
            $display("uart_power_command_line_parser_core test failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("uart_power_command_line_parser_core test failed");
        $finish;
    end

endmodule

FILE: files.f
design/upcp_pkg.sv
design/upcp_ram.sv
design/upcp_ctrl.sv
design/upcp_datapath.sv
design/uart_power_command_line_parser_core.sv
tb/sv/uart_power_command_line_parser_core_test.sv
